// File: hw/rtl/raised_cosine_mask_blend_top_macros.svh
// assertion macros for the raised-cosine mask blend block
// used by the top level only, no other dependencies
`ifndef RAISED_COSINE_MASK_BLEND_TOP_MACROS_SVH
`define RAISED_COSINE_MASK_BLEND_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define RCMB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RCMB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rcmb_pkg.sv
// shared types, constants and tap table of the raised-cosine mask blend block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rcmb_pkg;

    localparam int MAX_RADIUS = 8;
    localparam int ROM_RADII  = 8;
    localparam int MAX_BINS   = 4096;
    localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int EFF_RADIUS = (MAX_RADIUS < ROM_RADII) ? MAX_RADIUS : ROM_RADII;

    localparam int RADIUS_W  = 4;
    localparam int BIN_CNT_W = ($clog2(MAX_BINS) > 0) ? $clog2(MAX_BINS) : 1;
    localparam int AGE_W     = $clog2(WIN_DEPTH);
    localparam int PEND_W    = $clog2(MAX_RADIUS + 2);
    localparam int K_W       = $clog2(MAX_RADIUS + 1) + 1;
    localparam int Q_W       = 16;
    localparam int STEP_W    = $clog2(Q_W);
    // sum of all taps of the widest window stays below 2^19
    localparam int ACC_W     = 19;

    localparam logic [RADIUS_W-1:0]  RADIUS_RESET = RADIUS_W'(2);
    localparam logic [RADIUS_W-1:0]  RADIUS_LIMIT = RADIUS_W'(EFF_RADIUS);
    localparam logic [BIN_CNT_W-1:0] LAST_BIN_IDX = BIN_CNT_W'(MAX_BINS - 1);
    localparam logic [Q_W-1:0]       ONE_Q15      = 16'd32768;
    localparam logic [Q_W-1:0]       CAP_Q15      = 16'd11468;

    typedef logic [ACC_W-1:0] acc_t;
    typedef logic [Q_W-1:0]   q_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ACC,
        ST_DIV_GO,
        ST_DIV,
        ST_OUT
    } state_t;

    // raised-cosine taps per radius, rounded to q1.15
    localparam logic [Q_W-1:0] TAP_ROM [0:ROM_RADII][0:ROM_RADII] = '{
        '{16'd32768, 16'd0,     16'd0,     16'd0,     16'd0,
          16'd0,     16'd0,     16'd0,     16'd0},
        '{16'd32768, 16'd16384, 16'd0,     16'd0,     16'd0,
          16'd0,     16'd0,     16'd0,     16'd0},
        '{16'd32768, 16'd24576, 16'd8192,  16'd0,     16'd0,
          16'd0,     16'd0,     16'd0,     16'd0},
        '{16'd32768, 16'd27969, 16'd16384, 16'd4799,  16'd0,
          16'd0,     16'd0,     16'd0,     16'd0},
        '{16'd32768, 16'd29639, 16'd21447, 16'd11321, 16'd3129,
          16'd0,     16'd0,     16'd0,     16'd0},
        '{16'd32768, 16'd30573, 16'd24576, 16'd16384, 16'd8192,
          16'd2195,  16'd0,     16'd0,     16'd0},
        '{16'd32768, 16'd31145, 16'd26599, 16'd20030, 16'd12738,
          16'd6169,  16'd1623,  16'd0,     16'd0},
        '{16'd32768, 16'd31521, 16'd27969, 16'd22654, 16'd16384,
          16'd10114, 16'd4799,  16'd1247,  16'd0},
        '{16'd32768, 16'd31780, 16'd28935, 16'd24576, 16'd19229,
          16'd13539, 16'd8192,  16'd3833,  16'd988}
    };

endpackage

`default_nettype wire

// File: hw/rtl/rcmb_in_if.sv
// input channel of the mask blend block: one damage flag per transaction
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface rcmb_in_if;
    logic valid;
    logic ready;
    logic damaged;
    logic last_bin;

    modport source (output valid, output damaged, output last_bin, input ready);
    modport sink   (input valid, input damaged, input last_bin, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rcmb_out_if.sv
// output channel of the mask blend block: one q1.15 weight per transaction
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface rcmb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] weight;
    logic        frame_end;

    modport source (output valid, output weight, output frame_end, input ready);
    modport sink   (input valid, input weight, input frame_end, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rcmb_divider.sv
// restoring divider, one quotient bit per cycle: floor(dividend * 2^15 / divisor)
// depends on rcmb_pkg; dividend must not exceed divisor
`timescale 1ns / 1ps
`default_nettype none

module rcmb_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire rcmb_pkg::acc_t    dividend,
    input  wire rcmb_pkg::acc_t    divisor,
    output rcmb_pkg::div_stat_t    stat,
    output rcmb_pkg::q_t           quotient
);
    import rcmb_pkg::*;

    acc_t              rem_reg, rem_next;
    acc_t              dvs_reg;
    q_t                q_reg, q_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ACC_W:0]    trial;
    logic              fits;

    // first step takes the integer bit, later steps shift in a zero
    assign trial = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            q_next    = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? ACC_W'(trial - {1'b0, dvs_reg}) : ACC_W'(trial);
            q_next    = {q_reg[Q_W-2:0], fits};
            step_next = STEP_W'(step_reg + 1'b1);
            if (step_reg == STEP_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

`default_nettype wire

// File: hw/rtl/raised_cosine_mask_blend_top.sv
// top level of the raised-cosine mask blend block
// depends on rcmb_pkg, rcmb_in_if, rcmb_out_if, rcmb_divider and the macros header
//
//  channel   direction  payload                      width
//  in_ch     sink       damaged, last_bin            1 + 1
//  out_ch    source     weight (q1.15), frame_end    16 + 1
//  cfg       write      cfg_wdata = radius           4
//
// one transaction in, then 0 to 9 results; each result passes a check, an
// accumulation over 2r+1 taps, a divider start, 16 divider steps, a quotient
// pick-up and the output state (r = radius capped at 8); each input is accepted
// in the idle state and then checked; one restoring divider computes every result
// in_ch.ready is high only in the idle state; out_ch holds its result until taken
// rst_n clears the fsm, counters, flag window and sets radius to 2; no clearing pass
`include "raised_cosine_mask_blend_top_macros.svh"
`timescale 1ns / 1ps
`default_nettype none

module raised_cosine_mask_blend_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rcmb_pkg::RADIUS_W-1:0]  cfg_wdata,
    rcmb_in_if.sink                             in_ch,
    rcmb_out_if.source                          out_ch
);
    import rcmb_pkg::*;

    // fsm and configuration
    state_t                state_reg, state_next;
    logic [RADIUS_W-1:0]   radius_reg;

    // frame bookkeeping
    logic [WIN_DEPTH-1:0]  window_reg, window_next;   // bit 0 holds the newest flag
    logic [BIN_CNT_W-1:0]  seen_reg, seen_next;
    logic [PEND_W-1:0]     pend_reg, pend_next;       // bins taken but not yet given out
    logic [PEND_W-1:0]     done_sat_reg, done_sat_next; // bins given out, saturating
    logic                  end_reg, end_next;
    logic [RADIUS_W-1:0]   r_reg, r_next;             // radius frozen for this transaction

    // accumulation
    logic signed [K_W-1:0] k_reg, k_next;
    acc_t                  sum_reg, sum_next;
    acc_t                  total_reg, total_next;
    logic                  centre_reg, centre_next;

    // result register
    logic [Q_W-1:0]        weight_reg, weight_next;
    logic                  fend_reg, fend_next;

    // divider link
    logic                  div_start;
    div_stat_t             div_stat;
    q_t                    div_q;

    // tap address arithmetic
    logic [PEND_W-1:0]     age_centre;
    logic signed [AGE_W:0] age_nb;
    logic signed [AGE_W:0] pos_nb;
    logic [RADIUS_W-1:0]   k_abs;
    logic                  nb_in_frame;
    logic                  nb_flag;
    logic [Q_W-1:0]        tap;
    logic                  in_acc;
    logic                  emit_due;

    rcmb_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (total_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // neighbour of the oldest pending bin, offset k
    assign age_centre  = PEND_W'(pend_reg - 1'b1);
    assign age_nb      = $signed({{(AGE_W+1-PEND_W){1'b0}}, age_centre})
                         - $signed({{(AGE_W+1-K_W){k_reg[K_W-1]}}, k_reg});
    // sign of emitted + k tells whether the neighbour lies before the frame start
    assign pos_nb      = $signed({{(AGE_W+1-PEND_W){1'b0}}, done_sat_reg})
                         + $signed({{(AGE_W+1-K_W){k_reg[K_W-1]}}, k_reg});
    assign k_abs       = k_reg[K_W-1] ? RADIUS_W'(-k_reg) : RADIUS_W'(k_reg);
    assign nb_in_frame = !age_nb[AGE_W] && !pos_nb[AGE_W];
    assign nb_flag     = window_reg[age_nb[AGE_W-1:0]];
    assign tap         = TAP_ROM[r_reg][k_abs];
    assign in_acc      = (state_reg == ST_ACC);
    // a result is due once radius bins of lookahead are in, or at frame end
    assign emit_due    = (pend_reg != '0) && (end_reg || (pend_reg > PEND_W'(r_reg)));

    always_comb
    begin
        state_next    = state_reg;
        window_next   = window_reg;
        seen_next     = seen_reg;
        pend_next     = pend_reg;
        done_sat_next = done_sat_reg;
        end_next      = end_reg;
        r_next        = r_reg;
        k_next        = k_reg;
        sum_next      = sum_reg;
        total_next    = total_reg;
        centre_next   = centre_reg;
        weight_next   = weight_reg;
        fend_next     = fend_reg;
        div_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    window_next = {window_reg[WIN_DEPTH-2:0], in_ch.damaged};
                    pend_next   = PEND_W'(pend_reg + 1'b1);
                    end_next    = in_ch.last_bin || (seen_reg == LAST_BIN_IDX);
                    seen_next   = end_next ? '0 : BIN_CNT_W'(seen_reg + 1'b1);
                    r_next      = (radius_reg > RADIUS_LIMIT) ? RADIUS_LIMIT : radius_reg;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (emit_due)
                begin
                    k_next     = -$signed(K_W'(r_reg));
                    sum_next   = '0;
                    total_next = '0;
                    state_next = ST_ACC;
                end
                else
                begin
                    // frame end: all pending bins are out, start afresh
                    if (end_reg)
                    begin
                        window_next   = '0;
                        done_sat_next = '0;
                        end_next      = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_ACC:
            begin
                if (nb_in_frame)
                begin
                    total_next = ACC_W'(total_reg + tap);
                    if (nb_flag)
                    begin
                        sum_next = ACC_W'(sum_reg + tap);
                    end
                end
                if (k_reg == '0)
                begin
                    centre_next = nb_flag;
                end
                if (k_reg == $signed(K_W'(r_reg)))
                begin
                    state_next = ST_DIV_GO;
                end
                else
                begin
                    k_next = K_W'(k_reg + 1'b1);
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    priority if (centre_reg)
                    begin
                        weight_next = ONE_Q15;
                    end
                    else if (div_q > CAP_Q15)
                    begin
                        weight_next = CAP_Q15;
                    end
                    else
                    begin
                        weight_next = div_q;
                    end
                    fend_next  = end_reg && (pend_reg == PEND_W'(1));
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    pend_next = PEND_W'(pend_reg - 1'b1);
                    if (done_sat_reg != PEND_W'(MAX_RADIUS))
                    begin
                        done_sat_next = PEND_W'(done_sat_reg + 1'b1);
                    end
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            radius_reg   <= RADIUS_RESET;
            window_reg   <= '0;
            seen_reg     <= '0;
            pend_reg     <= '0;
            done_sat_reg <= '0;
            end_reg      <= 1'b0;
            r_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            window_reg   <= window_next;
            seen_reg     <= seen_next;
            pend_reg     <= pend_next;
            done_sat_reg <= done_sat_next;
            end_reg      <= end_next;
            r_reg        <= r_next;
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        sum_reg    <= sum_next;
        total_reg  <= total_next;
        centre_reg <= centre_next;
        weight_reg <= weight_next;
        fend_reg   <= fend_next;
    end

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = (state_reg == ST_OUT);
    assign out_ch.weight    = weight_reg;
    assign out_ch.frame_end = fend_reg;

    // a shown weight is either exactly one or no more than the cap
    `RCMB_ASSERT_NOW(a_weight_range, clk, rst_n, out_ch.valid,
        (out_ch.weight == ONE_Q15) || (out_ch.weight <= CAP_Q15),
        "weight outside one or capped range")
    // never take a new bin while a result waits
    `RCMB_ASSERT_NOW(a_no_overlap, clk, rst_n, out_ch.valid, !in_ch.ready,
        "input ready while a result is pending")
    // pending bins never exceed the widest lookahead plus one
    `RCMB_ASSERT_NOW(a_pend_bound, clk, rst_n, 1'b1, pend_reg <= PEND_W'(MAX_RADIUS + 1),
        "pending count overflow")
    // a frame-end result empties the pending set
    `RCMB_ASSERT_NEXT(a_frame_flush, clk, rst_n,
        out_ch.valid && out_ch.ready && out_ch.frame_end, pend_reg == '0,
        "bins left pending after frame end")
    // accumulation only on a non-empty pending set
    `RCMB_ASSERT_NOW(a_acc_pending, clk, rst_n, in_acc, pend_reg != '0,
        "accumulating with nothing pending")

endmodule

`default_nettype wire
